// ===== rtl/bbsm_pkg.sv =====
// Shared types and constants for the bit-banged serial bus master.
package bbsm_pkg;

    typedef enum logic [3:0] {
        OP_START   = 4'd0,
        OP_STOP    = 4'd1,
        OP_WRBYTE  = 4'd2,
        OP_RDBYTE  = 4'd3,
        OP_XCHG    = 4'd4,
        OP_WRBIT   = 4'd5,
        OP_RDBIT   = 4'd6,
        OP_TICKS   = 4'd7,
        OP_SETDATA = 4'd8,
        OP_SETCLK  = 4'd9,
        OP_SETSEL  = 4'd10,
        OP_SAMPLE  = 4'd11
    } opcode_t;

    localparam logic [2:0] REG_SETTLE     = 3'd0;
    localparam logic [2:0] REG_CLOCK      = 3'd1;
    localparam logic [2:0] REG_LSB_FIRST  = 3'd2;
    localparam logic [2:0] REG_OPEN_DRAIN = 3'd3;
    localparam logic [2:0] REG_THREE_WIRE = 3'd4;

    localparam logic [7:0] RST_SETTLE = 8'd20;
    localparam logic [7:0] RST_CLOCK  = 8'd100;

    // One tick as classified by the front end.
    typedef struct packed {
        logic       cmd;
        logic [3:0] op;
        logic [7:0] data;
        logic       data_pin;
        logic       miso_pin;
    } tick_t;

    // One result item.
    typedef struct packed {
        logic       data_latch;
        logic       data_drive;
        logic       clk_latch;
        logic       clk_drive;
        logic       sel_latch;
        logic       sel_drive;
        logic       busy;
        logic       read_valid;
        logic [7:0] read_data;
    } result_t;

    typedef struct packed {
        logic [7:0] settle_us;
        logic [7:0] clock_us;
        logic       lsb_first;
        logic       open_drain;
        logic       three_wire;
    } cfg_t;

endpackage

// ===== rtl/bbsm_front.sv =====
// Front end: configuration registers and tick classification.
module bbsm_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    input  logic              cmd_valid,
    input  logic [3:0]        opcode,
    input  logic [7:0]        cmd_data,
    input  logic              data_pin_in,
    input  logic              miso_pin_in,
    output bbsm_pkg::cfg_t    cfg,
    output bbsm_pkg::tick_t   tick
);

    bbsm_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_us  <= bbsm_pkg::RST_SETTLE;
            cfg_reg.clock_us   <= bbsm_pkg::RST_CLOCK;
            cfg_reg.lsb_first  <= 1'b0;
            cfg_reg.open_drain <= 1'b0;
            cfg_reg.three_wire <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bbsm_pkg::REG_SETTLE:     cfg_reg.settle_us  <= cfg_data;
                bbsm_pkg::REG_CLOCK:      cfg_reg.clock_us   <= cfg_data;
                bbsm_pkg::REG_LSB_FIRST:  cfg_reg.lsb_first  <= cfg_data[0];
                bbsm_pkg::REG_OPEN_DRAIN: cfg_reg.open_drain <= cfg_data[0];
                bbsm_pkg::REG_THREE_WIRE: cfg_reg.three_wire <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

    // Unknown opcodes lose their command flag here so the back end never runs them.
    always_comb
    begin
        tick.cmd      = cmd_valid && (opcode <= bbsm_pkg::OP_SAMPLE);
        tick.op       = opcode;
        tick.data     = cmd_data;
        tick.data_pin = data_pin_in;
        tick.miso_pin = miso_pin_in;
    end

endmodule

// ===== rtl/bbsm_queue.sv =====
// Two-entry queue that carries ticks or results between stages.
module bbsm_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [23:0]           wdata,
    output logic                  full,
    input  logic                  pop,
    output logic [23:0]           rdata,
    output logic                  empty
);

    logic [23:0] mem_reg [2];
    logic        wptr_reg, rptr_reg;
    logic [1:0]  count_reg;
    logic        do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push) wptr_reg <= !wptr_reg;
            if (do_pop)  rptr_reg <= !rptr_reg;
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 2'd2)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> !empty)
        else $error("queue lost a transaction");
    assert property (@(posedge clk) disable iff (!rst_n)
        (full && !do_pop) |=> full)
        else $error("full dropped without a pop");

endmodule

// ===== rtl/bbsm_back.sv =====
// Back end: the step sequencer that drives the pins and assembles reads.
module bbsm_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  bbsm_pkg::cfg_t    cfg,
    input  logic              tick_valid,
    input  bbsm_pkg::tick_t   tick,
    output logic              tick_pop,
    output logic              res_push,
    output bbsm_pkg::result_t res,
    input  logic              res_full
);

    logic [3:0] phase_reg, phase_next;
    logic [3:0] op_reg, op_next;
    logic [7:0] hold_reg, hold_next;
    logic [7:0] so_reg, so_next, si_reg, si_next, ticks_reg, ticks_next;
    logic [3:0] bit_reg, bit_next;
    logic       dl_reg, dd_reg, cl_reg, cd_reg, sl_reg, sd_reg;
    logic       dl_next, dd_next, cl_next, cd_next, sl_next, sd_next;
    logic       rv;
    logic [7:0] rd;
    logic       go;
    logic [3:0] nx;
    logic [7:0] dset, dclk;
    logic       in_bit, xbit;

    assign go       = tick_valid && !res_full;
    assign tick_pop = go;
    assign res_push = go;
    assign dset     = (cfg.settle_us == 8'd0) ? 8'd1 : cfg.settle_us;
    assign dclk     = (cfg.clock_us == 8'd0) ? 8'd1 : cfg.clock_us;

    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        hold_next  = hold_reg;
        so_next    = so_reg;
        si_next    = si_reg;
        ticks_next = ticks_reg;
        bit_next   = bit_reg;
        dl_next = dl_reg; dd_next = dd_reg;
        cl_next = cl_reg; cd_next = cd_reg;
        sl_next = sl_reg; sd_next = sd_reg;
        rv = 1'b0;
        rd = 8'd0;
        nx = 4'd0;
        in_bit = 1'b0;
        xbit = 1'b0;
        if (phase_reg != 4'd0)
        begin
            if (hold_reg > 8'd1)
            begin
                hold_next = hold_reg - 8'd1;
            end
            else
            begin
                case (op_reg)
                    bbsm_pkg::OP_START, bbsm_pkg::OP_STOP:
                        nx = (phase_reg < 4'd4) ? phase_reg + 4'd1 : 4'd0;
                    bbsm_pkg::OP_WRBYTE, bbsm_pkg::OP_XCHG:
                    begin
                        if (phase_reg < 4'd3) nx = phase_reg + 4'd1;
                        else
                        begin
                            bit_next = bit_reg + 4'd1;
                            nx = (bit_next < 4'd8) ? 4'd1 : 4'd0;
                        end
                    end
                    bbsm_pkg::OP_RDBYTE:
                    begin
                        if (phase_reg < 4'd2) nx = phase_reg + 4'd1;
                        else
                        begin
                            bit_next = bit_reg + 4'd1;
                            nx = (bit_next < 4'd8) ? 4'd1 : 4'd0;
                        end
                    end
                    bbsm_pkg::OP_WRBIT:
                        nx = (phase_reg < 4'd3) ? phase_reg + 4'd1 : 4'd0;
                    bbsm_pkg::OP_RDBIT:
                        nx = (phase_reg < 4'd2) ? phase_reg + 4'd1 : 4'd0;
                    bbsm_pkg::OP_TICKS:
                    begin
                        if (phase_reg < 4'd2) nx = phase_reg + 4'd1;
                        else
                        begin
                            ticks_next = ticks_reg - 8'd1;
                            nx = (ticks_next != 8'd0) ? 4'd1 : 4'd0;
                        end
                    end
                    default: nx = 4'd0;
                endcase
                if (nx == 4'd0)
                begin
                    phase_next = 4'd0;
                    hold_next  = 8'd0;
                    if (op_reg == bbsm_pkg::OP_RDBYTE || op_reg == bbsm_pkg::OP_XCHG
                        || op_reg == bbsm_pkg::OP_RDBIT)
                    begin
                        rv = 1'b1;
                        rd = si_reg;
                    end
                end
                else
                begin
                    phase_next = nx;
                end
            end
        end
        else if (tick.cmd)
        begin
            op_next    = tick.op;
            so_next    = tick.data;
            si_next    = 8'd0;
            bit_next   = 4'd0;
            ticks_next = tick.data;
            if (tick.op == bbsm_pkg::OP_SAMPLE)
            begin
                rv = 1'b1;
                if (cfg.three_wire) rd = {7'd0, tick.miso_pin};
                else
                begin
                    dd_next = 1'b0;
                    rd = {7'd0, tick.data_pin};
                end
            end
            else if (!(tick.op == bbsm_pkg::OP_TICKS && tick.data == 8'd0))
            begin
                phase_next = 4'd1;
            end
        end

        // Step action, taken whenever a new phase is entered.
        if (phase_next != 4'd0 && (phase_reg == 4'd0 || hold_reg <= 8'd1))
        begin
            xbit = cfg.lsb_first ? so_next[0] : so_next[7];
            hold_next = dclk;
            case (op_next)
                bbsm_pkg::OP_START:
                begin
                    if (phase_next == 4'd1)
                    begin
                        if (cfg.open_drain) dd_next = 1'b0; else begin dl_next = 1'b1; dd_next = 1'b1; end
                        if (cfg.open_drain) cd_next = 1'b0; else begin cl_next = 1'b1; cd_next = 1'b1; end
                    end
                    else if (phase_next == 4'd2) begin dl_next = 1'b0; dd_next = 1'b1; end
                    else if (phase_next == 4'd3) begin cl_next = 1'b0; cd_next = 1'b1; end
                    else if (cfg.open_drain) dd_next = 1'b0;
                    else begin dl_next = 1'b1; dd_next = 1'b1; end
                end
                bbsm_pkg::OP_STOP:
                begin
                    if (phase_next == 4'd1)
                    begin
                        dl_next = 1'b0; dd_next = 1'b1; cl_next = 1'b0; cd_next = 1'b1;
                    end
                    else if (phase_next == 4'd2)
                    begin
                        if (cfg.open_drain) cd_next = 1'b0; else begin cl_next = 1'b1; cd_next = 1'b1; end
                    end
                    else if (phase_next == 4'd3)
                    begin
                        if (cfg.open_drain) dd_next = 1'b0; else begin dl_next = 1'b1; dd_next = 1'b1; end
                    end
                    else begin cl_next = 1'b0; cd_next = 1'b1; end
                end
                bbsm_pkg::OP_WRBYTE, bbsm_pkg::OP_XCHG, bbsm_pkg::OP_WRBIT:
                begin
                    if (op_next == bbsm_pkg::OP_WRBIT) xbit = (so_next != 8'd0);
                    if (phase_next == 4'd1)
                    begin
                        hold_next = dset;
                        if (!xbit) begin dl_next = 1'b0; dd_next = 1'b1; end
                        else if (cfg.open_drain) dd_next = 1'b0;
                        else begin dl_next = 1'b1; dd_next = 1'b1; end
                    end
                    else if (phase_next == 4'd2)
                    begin
                        if (cfg.open_drain) cd_next = 1'b0; else begin cl_next = 1'b1; cd_next = 1'b1; end
                    end
                    else
                    begin
                        if (op_next == bbsm_pkg::OP_XCHG)
                        begin
                            si_next = cfg.lsb_first ? {tick.miso_pin, si_reg[7:1]}
                                                    : {si_reg[6:0], tick.miso_pin};
                        end
                        cl_next = 1'b0; cd_next = 1'b1;
                        if (op_next != bbsm_pkg::OP_WRBIT)
                        begin
                            so_next = cfg.lsb_first ? {1'b0, so_reg[7:1]} : {so_reg[6:0], 1'b0};
                        end
                    end
                end
                bbsm_pkg::OP_RDBYTE:
                begin
                    dd_next = 1'b0;
                    if (phase_next == 4'd1)
                    begin
                        if (cfg.open_drain) cd_next = 1'b0; else begin cl_next = 1'b1; cd_next = 1'b1; end
                    end
                    else
                    begin
                        si_next = cfg.lsb_first ? {tick.data_pin, si_reg[7:1]}
                                                : {si_reg[6:0], tick.data_pin};
                        cl_next = 1'b0; cd_next = 1'b1;
                    end
                end
                bbsm_pkg::OP_RDBIT:
                begin
                    if (phase_next == 4'd1)
                    begin
                        if (!cfg.three_wire) dd_next = 1'b0;
                        if (cfg.open_drain) cd_next = 1'b0; else begin cl_next = 1'b1; cd_next = 1'b1; end
                    end
                    else
                    begin
                        in_bit = cfg.three_wire ? tick.miso_pin : tick.data_pin;
                        if (!cfg.three_wire) dd_next = 1'b0;
                        si_next = {7'd0, in_bit};
                        cl_next = 1'b0; cd_next = 1'b1;
                    end
                end
                bbsm_pkg::OP_TICKS:
                begin
                    if (phase_next == 4'd1)
                    begin
                        if (cfg.open_drain) cd_next = 1'b0; else begin cl_next = 1'b1; cd_next = 1'b1; end
                    end
                    else begin cl_next = 1'b0; cd_next = 1'b1; end
                end
                bbsm_pkg::OP_SETDATA:
                begin
                    hold_next = dset;
                    if (so_next == 8'd0) begin dl_next = 1'b0; dd_next = 1'b1; end
                    else if (cfg.open_drain) dd_next = 1'b0;
                    else begin dl_next = 1'b1; dd_next = 1'b1; end
                end
                bbsm_pkg::OP_SETCLK:
                begin
                    hold_next = dset;
                    if (so_next == 8'd0) begin cl_next = 1'b0; cd_next = 1'b1; end
                    else if (cfg.open_drain) cd_next = 1'b0;
                    else begin cl_next = 1'b1; cd_next = 1'b1; end
                end
                default:
                begin
                    hold_next = dset;
                    if (so_next == 8'd0) begin sl_next = 1'b0; sd_next = 1'b1; end
                    else if (cfg.open_drain) sd_next = 1'b0;
                    else begin sl_next = 1'b1; sd_next = 1'b1; end
                end
            endcase
        end

        res.data_latch = dl_next;
        res.data_drive = dd_next;
        res.clk_latch  = cl_next;
        res.clk_drive  = cd_next;
        res.sel_latch  = sl_next;
        res.sel_drive  = sd_next;
        res.busy       = (phase_next != 4'd0);
        res.read_valid = rv;
        res.read_data  = rd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 4'd0; op_reg <= 4'd0; hold_reg <= 8'd0;
            so_reg <= 8'd0; si_reg <= 8'd0; ticks_reg <= 8'd0; bit_reg <= 4'd0;
            dl_reg <= 1'b0; dd_reg <= 1'b0; cl_reg <= 1'b0;
            cd_reg <= 1'b0; sl_reg <= 1'b0; sd_reg <= 1'b0;
        end
        else if (go)
        begin
            phase_reg <= phase_next; op_reg <= op_next; hold_reg <= hold_next;
            so_reg <= so_next; si_reg <= si_next; ticks_reg <= ticks_next;
            bit_reg <= bit_next;
            dl_reg <= dl_next; dd_reg <= dd_next; cl_reg <= cl_next;
            cd_reg <= cd_next; sl_reg <= sl_next; sd_reg <= sd_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != 4'd0) |-> (hold_reg != 8'd0))
        else $error("running step with no hold");
    assert property (@(posedge clk) disable iff (!rst_n)
        (go && phase_reg != 4'd0 && hold_reg > 8'd1) |=> $stable(phase_reg))
        else $error("phase moved during hold");
    assert property (@(posedge clk) disable iff (!rst_n) bit_reg <= 4'd8)
        else $error("bit index out of range");

endmodule

// ===== rtl/bitbang_serial_master.sv =====
// Top level of the bit-banged serial bus master.
// Each pushed transaction is one timing tick, optionally carrying a command,
// and yields exactly one result transaction with the pin state after that tick.
// Ticks are taken one per clock cycle while full is low. A tick passes a
// two-entry queue into the step sequencer, which handles one tick per cycle
// while the result queue has room; its result goes out through a two-entry
// result queue, so the input keeps one transaction per cycle while pop keeps up.
// Commands that arrive while a sequence runs are ignored.
module bitbang_serial_master
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       push,
    output logic       full,
    input  logic       cmd_valid,
    input  logic [3:0] opcode,
    input  logic [7:0] cmd_data,
    input  logic       data_pin_in,
    input  logic       miso_pin_in,
    output logic       empty,
    input  logic       pop,
    output logic       data_latch,
    output logic       data_drive,
    output logic       clk_latch,
    output logic       clk_drive,
    output logic       sel_latch,
    output logic       sel_drive,
    output logic       busy_res,
    output logic       read_valid,
    output logic [7:0] read_data
);

    bbsm_pkg::cfg_t    cfg;
    bbsm_pkg::tick_t   tick_in, tick_q;
    bbsm_pkg::result_t res, res_q;
    logic [23:0]       tick_raw, res_raw;
    logic              tq_empty, tick_pop, res_push, res_full;
    logic [23:0]       tick_w, res_w;

    bbsm_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .cmd_valid(cmd_valid), .opcode(opcode), .cmd_data(cmd_data),
        .data_pin_in(data_pin_in), .miso_pin_in(miso_pin_in),
        .cfg(cfg), .tick(tick_in)
    );

    assign tick_w = {9'd0, tick_in};
    assign tick_q = tick_raw[14:0];

    bbsm_queue u_tick_q
    (
        .clk(clk), .rst_n(rst_n),
        .push(push), .wdata(tick_w), .full(full),
        .pop(tick_pop), .rdata(tick_raw), .empty(tq_empty)
    );

    bbsm_back u_back
    (
        .clk(clk), .rst_n(rst_n), .cfg(cfg),
        .tick_valid(!tq_empty), .tick(tick_q), .tick_pop(tick_pop),
        .res_push(res_push), .res(res), .res_full(res_full)
    );

    assign res_w = {8'd0, res};
    assign res_q = res_raw[15:0];

    bbsm_queue u_res_q
    (
        .clk(clk), .rst_n(rst_n),
        .push(res_push), .wdata(res_w), .full(res_full),
        .pop(pop), .rdata(res_raw), .empty(empty)
    );

    assign data_latch = res_q.data_latch;
    assign data_drive = res_q.data_drive;
    assign clk_latch  = res_q.clk_latch;
    assign clk_drive  = res_q.clk_drive;
    assign sel_latch  = res_q.sel_latch;
    assign sel_drive  = res_q.sel_drive;
    assign busy_res   = res_q.busy;
    assign read_valid = res_q.read_valid;
    assign read_data  = res_q.read_data;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the bit-banged serial bus master sequencer.
module testbench;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;
    logic       push = 1'b0;
    logic       full;
    logic       cmd_valid = 1'b0;
    logic [3:0] opcode = '0;
    logic [7:0] cmd_data = '0;
    logic       data_pin_in = 1'b0;
    logic       miso_pin_in = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic       data_latch, data_drive, clk_latch, clk_drive, sel_latch, sel_drive;
    logic       busy_res, read_valid;
    logic [7:0] read_data;

    bitbang_serial_master dut (.*);

    always #10 clk = ~clk;

    // Predictor state.
    bbsm_pkg::cfg_t       pcfg;
    logic                 p_dl, p_dd, p_cl, p_cd, p_sl, p_sd;
    logic [7:0]           p_sout, p_sin, p_ticks, p_hold;
    logic [3:0]           p_bit, p_phase;
    bbsm_pkg::opcode_t    p_op;

    bbsm_pkg::result_t    expected_q[$];
    int         errors = 0;
    int         ticks_sent = 0;
    int         reads_seen = 0;
    int         idle_cycles = 0;
    int         hold_off = 0;
    bit         quiet = 1'b0;
    bit         in_done = 1'b0;
    logic       cur_di, cur_mi;

    task automatic set_pin(inout logic lat, inout logic drv, input logic level);
        if (!level) begin lat = 1'b0; drv = 1'b1; end
        else if (pcfg.open_drain) drv = 1'b0;
        else begin lat = 1'b1; drv = 1'b1; end
    endtask

    function automatic logic [7:0] settle_dly();
        return (pcfg.settle_us == 8'd0) ? 8'd1 : pcfg.settle_us;
    endfunction

    function automatic logic [7:0] clock_dly();
        return (pcfg.clock_us == 8'd0) ? 8'd1 : pcfg.clock_us;
    endfunction

    task automatic shift_bit_in(input logic b);
        if (pcfg.lsb_first) p_sin = {b, p_sin[7:1]};
        else p_sin = {p_sin[6:0], b};
    endtask

    task automatic read_line(output logic b);
        if (pcfg.three_wire) b = cur_mi;
        else begin p_dd = 1'b0; b = cur_di; end
    endtask

    task automatic run_phase(output logic [7:0] hold);
        logic b;
        hold = clock_dly();
        case (p_op)
            bbsm_pkg::OP_START:
                case (p_phase)
                    4'd1: begin set_pin(p_dl, p_dd, 1'b1); set_pin(p_cl, p_cd, 1'b1); end
                    4'd2: set_pin(p_dl, p_dd, 1'b0);
                    4'd3: set_pin(p_cl, p_cd, 1'b0);
                    default: set_pin(p_dl, p_dd, 1'b1);
                endcase
            bbsm_pkg::OP_STOP:
                case (p_phase)
                    4'd1: begin set_pin(p_dl, p_dd, 1'b0); set_pin(p_cl, p_cd, 1'b0); end
                    4'd2: set_pin(p_cl, p_cd, 1'b1);
                    4'd3: set_pin(p_dl, p_dd, 1'b1);
                    default: set_pin(p_cl, p_cd, 1'b0);
                endcase
            bbsm_pkg::OP_WRBYTE, bbsm_pkg::OP_XCHG:
                if (p_phase == 4'd1) begin
                    set_pin(p_dl, p_dd, pcfg.lsb_first ? p_sout[0] : p_sout[7]);
                    hold = settle_dly();
                end else if (p_phase == 4'd2) set_pin(p_cl, p_cd, 1'b1);
                else begin
                    if (p_op == bbsm_pkg::OP_XCHG) shift_bit_in(cur_mi);
                    set_pin(p_cl, p_cd, 1'b0);
                    p_sout = pcfg.lsb_first ? p_sout >> 1 : p_sout << 1;
                end
            bbsm_pkg::OP_RDBYTE:
                begin
                    p_dd = 1'b0;
                    if (p_phase == 4'd1) set_pin(p_cl, p_cd, 1'b1);
                    else begin shift_bit_in(cur_di); set_pin(p_cl, p_cd, 1'b0); end
                end
            bbsm_pkg::OP_WRBIT:
                if (p_phase == 4'd1) begin
                    set_pin(p_dl, p_dd, p_sout != 8'd0);
                    hold = settle_dly();
                end else set_pin(p_cl, p_cd, p_phase == 4'd2);
            bbsm_pkg::OP_RDBIT:
                if (p_phase == 4'd1) begin
                    if (!pcfg.three_wire) p_dd = 1'b0;
                    set_pin(p_cl, p_cd, 1'b1);
                end else begin
                    read_line(b);
                    p_sin = {7'd0, b};
                    set_pin(p_cl, p_cd, 1'b0);
                end
            bbsm_pkg::OP_TICKS: set_pin(p_cl, p_cd, p_phase == 4'd1);
            bbsm_pkg::OP_SETDATA:
                begin set_pin(p_dl, p_dd, p_sout != 8'd0); hold = settle_dly(); end
            bbsm_pkg::OP_SETCLK:
                begin set_pin(p_cl, p_cd, p_sout != 8'd0); hold = settle_dly(); end
            default: begin set_pin(p_sl, p_sd, p_sout != 8'd0); hold = settle_dly(); end
        endcase
    endtask

    function automatic logic [3:0] following_phase();
        case (p_op)
            bbsm_pkg::OP_START, bbsm_pkg::OP_STOP:
                return (p_phase < 4'd4) ? p_phase + 4'd1 : 4'd0;
            bbsm_pkg::OP_WRBYTE, bbsm_pkg::OP_XCHG, bbsm_pkg::OP_RDBYTE:
                begin
                    if (p_phase < ((p_op == bbsm_pkg::OP_RDBYTE) ? 4'd2 : 4'd3))
                        return p_phase + 4'd1;
                    p_bit = p_bit + 4'd1;
                    return (p_bit < 4'd8) ? 4'd1 : 4'd0;
                end
            bbsm_pkg::OP_WRBIT: return (p_phase < 4'd3) ? p_phase + 4'd1 : 4'd0;
            bbsm_pkg::OP_RDBIT: return (p_phase < 4'd2) ? p_phase + 4'd1 : 4'd0;
            bbsm_pkg::OP_TICKS:
                begin
                    if (p_phase < 4'd2) return p_phase + 4'd1;
                    p_ticks = p_ticks - 8'd1;
                    return (p_ticks != 8'd0) ? 4'd1 : 4'd0;
                end
            default: return 4'd0;
        endcase
    endfunction

    task automatic predict_tick(input bbsm_pkg::tick_t t);
        bbsm_pkg::result_t r;
        logic [3:0]        nx;
        logic              b;
        r = '0;
        cur_di = t.data_pin;
        cur_mi = t.miso_pin;
        if (p_phase != 4'd0) begin
            if (p_hold > 8'd1) p_hold = p_hold - 8'd1;
            else begin
                nx = following_phase();
                if (nx != 4'd0) begin
                    p_phase = nx;
                    run_phase(p_hold);
                end else begin
                    p_phase = 4'd0;
                    p_hold = 8'd0;
                    if (p_op inside {bbsm_pkg::OP_RDBYTE, bbsm_pkg::OP_XCHG,
                                     bbsm_pkg::OP_RDBIT}) begin
                        r.read_valid = 1'b1;
                        r.read_data = p_sin;
                    end
                end
            end
        end else if (t.cmd && t.op <= bbsm_pkg::OP_SAMPLE) begin
            p_op = bbsm_pkg::opcode_t'(t.op);
            p_sout = t.data;
            p_sin = '0;
            p_bit = '0;
            p_ticks = t.data;
            if (p_op == bbsm_pkg::OP_SAMPLE) begin
                read_line(b);
                r.read_valid = 1'b1;
                r.read_data = {7'd0, b};
            end else if (!(p_op == bbsm_pkg::OP_TICKS && t.data == 8'd0)) begin
                p_phase = 4'd1;
                run_phase(p_hold);
            end
        end
        r.data_latch = p_dl; r.data_drive = p_dd;
        r.clk_latch = p_cl;  r.clk_drive = p_cd;
        r.sel_latch = p_sl;  r.sel_drive = p_sd;
        r.busy = (p_phase != 4'd0);
        expected_q.push_back(r);
    endtask

    task automatic send_tick(input logic cv, input logic [3:0] op, input logic [7:0] d);
        bbsm_pkg::tick_t t;
        while (!quiet && $urandom_range(99) < 9) begin
            push <= 1'b0;
            @(posedge clk);
        end
        t = '{cmd: cv, op: op, data: d, data_pin: 1'($urandom_range(1)),
              miso_pin: 1'($urandom_range(1))};
        push <= 1'b1;
        cmd_valid <= t.cmd; opcode <= t.op; cmd_data <= t.data;
        data_pin_in <= t.data_pin; miso_pin_in <= t.miso_pin;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_tick(t);
        ticks_sent++;
    endtask

    task automatic run_cmd(input bbsm_pkg::opcode_t op, input logic [7:0] d);
        send_tick(1'b1, op, d);
        while (p_phase != 4'd0)
            send_tick($urandom_range(3) == 0, 4'($urandom), 8'($urandom));
    endtask

    task automatic drain();
        push <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] v);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
        @(posedge clk);
        case (idx)
            bbsm_pkg::REG_SETTLE: pcfg.settle_us = v;
            bbsm_pkg::REG_CLOCK: pcfg.clock_us = v;
            bbsm_pkg::REG_LSB_FIRST: pcfg.lsb_first = v[0];
            bbsm_pkg::REG_OPEN_DRAIN: pcfg.open_drain = v[0];
            bbsm_pkg::REG_THREE_WIRE: pcfg.three_wire = v[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [7:0] s, input logic [7:0] c,
                             input logic l, input logic o, input logic w);
        drain();
        write_reg(bbsm_pkg::REG_SETTLE, s);
        write_reg(bbsm_pkg::REG_CLOCK, c);
        write_reg(bbsm_pkg::REG_LSB_FIRST, {7'd0, l});
        write_reg(bbsm_pkg::REG_OPEN_DRAIN, {7'd0, o});
        write_reg(bbsm_pkg::REG_THREE_WIRE, {7'd0, w});
        cfg_we <= 1'b0;
    endtask

    task automatic test_directed();
        configure(8'd1, 8'd2, 1'b0, 1'b0, 1'b1);
        for (int i = 0; i <= 11; i++)
            run_cmd(bbsm_pkg::opcode_t'(i), (i == 7) ? 8'd2 : 8'hA5);
        run_cmd(bbsm_pkg::OP_TICKS, 8'd0);
        send_tick(1'b1, 4'd15, 8'hFF);
        send_tick(1'b1, bbsm_pkg::OP_WRBYTE, 8'hFF);
        send_tick(1'b1, bbsm_pkg::OP_SETSEL, 8'h00);
        while (p_phase != 4'd0) send_tick(1'b0, '0, '0);
        configure(8'd0, 8'd0, 1'b1, 1'b1, 1'b0);
        for (int i = 0; i <= 11; i++)
            run_cmd(bbsm_pkg::opcode_t'(i), (i == 7) ? 8'd1 : 8'h5A);
        run_cmd(bbsm_pkg::OP_SETDATA, 8'h00);
    endtask

    task automatic test_random(input int n);
        int         stop_at;
        logic [3:0] op;
        logic [7:0] d;
        stop_at = ticks_sent + n;
        while (ticks_sent < stop_at) begin
            op = 4'($urandom_range(15));
            d = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
            if (op == bbsm_pkg::OP_TICKS) d = 8'($urandom_range(4));
            if ($urandom_range(9) == 0) send_tick(1'($urandom_range(1)), op, d);
            else if (op <= bbsm_pkg::OP_SAMPLE) run_cmd(bbsm_pkg::opcode_t'(op), d);
        end
    endtask

    task automatic test_settings();
        configure(8'd37, 8'd5, 1'b0, 1'b1, 1'b1);
        run_cmd(bbsm_pkg::OP_SETCLK, 8'd1);
        run_cmd(bbsm_pkg::OP_WRBIT, 8'd0);
        configure(8'd1, 8'd1, 1'b1, 1'b0, 1'b0);
        test_random(60);
        configure(8'd1, 8'd2, 1'b0, 1'b1, 1'b1);
        test_random(60);
    endtask

    task automatic test_backpressure();
        configure(8'd1, 8'd1, 1'b0, 1'b0, 1'b1);
        hold_off = 60;
        quiet = 1'b1;
        test_random(100);
        quiet = 1'b0;
        drain();
        run_cmd(bbsm_pkg::OP_SAMPLE, 8'd0);
    endtask

    always @(posedge clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            pop <= 1'b0;
        end else pop <= quiet ? 1'b1 : ($urandom_range(99) >= 9);
    end

    always @(posedge clk) begin
        bbsm_pkg::result_t e;
        if (rst_n && pop && !empty) begin
            if (expected_q.size() == 0) begin
                $error("result with no tick outstanding");
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (read_valid) reads_seen++;
                if (data_latch !== e.data_latch) begin
                    $error("data_latch exp %0d got %0d", e.data_latch, data_latch); errors++; end
                if (data_drive !== e.data_drive) begin
                    $error("data_drive exp %0d got %0d", e.data_drive, data_drive); errors++; end
                if (clk_latch !== e.clk_latch) begin
                    $error("clk_latch exp %0d got %0d", e.clk_latch, clk_latch); errors++; end
                if (clk_drive !== e.clk_drive) begin
                    $error("clk_drive exp %0d got %0d", e.clk_drive, clk_drive); errors++; end
                if (sel_latch !== e.sel_latch) begin
                    $error("sel_latch exp %0d got %0d", e.sel_latch, sel_latch); errors++; end
                if (sel_drive !== e.sel_drive) begin
                    $error("sel_drive exp %0d got %0d", e.sel_drive, sel_drive); errors++; end
                if (busy_res !== e.busy) begin
                    $error("busy_res exp %0d got %0d", e.busy, busy_res); errors++; end
                if (read_valid !== e.read_valid) begin
                    $error("read_valid exp %0d got %0d", e.read_valid, read_valid); errors++; end
                if (read_data !== e.read_data) begin
                    $error("read_data exp %0h got %0h", e.read_data, read_data); errors++; end
            end
        end
    end

    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty) || in_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        pcfg = '{settle_us: bbsm_pkg::RST_SETTLE, clock_us: bbsm_pkg::RST_CLOCK,
                 lsb_first: 1'b0, open_drain: 1'b0, three_wire: 1'b1};
        {p_dl, p_dd, p_cl, p_cd, p_sl, p_sd} = '0;
        p_sout = '0; p_sin = '0; p_ticks = '0; p_hold = '0; p_bit = '0; p_phase = '0;
        p_op = bbsm_pkg::OP_START;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_settings();
        test_backpressure();
        drain();
        in_done = 1'b1;
        $display("Sent %0d ticks covering all opcodes, five register settings and a stall.",
                 ticks_sent);
        $display("Read results checked: %0d.", reads_seen);
        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== bitbang_serial_master.f =====
rtl/bbsm_pkg.sv
rtl/bbsm_front.sv
rtl/bbsm_queue.sv
rtl/bbsm_back.sv
rtl/bitbang_serial_master.sv
verif/testbench.sv
